### rtl/wpd_pkg.sv
package wpd_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int CHAN_W       = 4;
  localparam int POS_W        = 3;
  localparam int FRAME_W      = 24;
  localparam int POINT_W      = 16;
  localparam int PROD_W       = FRAME_W + POINT_W + 1;
  localparam int MAX_CH       = 8;
  localparam int RESULT_LIMIT = 64;
  localparam int CNT_W        = 7;
  localparam int CAP_SHIFT    = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT   = 2'd2;

  localparam logic [CHAN_W-1:0]  RST_CHANNEL_COUNT = 4'd2;
  localparam logic [FRAME_W-1:0] RST_FRAME_COUNT   = 24'd1;
  localparam logic [POINT_W-1:0] RST_POINT_COUNT   = 16'd1024;

  // effective run settings after clamping
  typedef struct packed {
    logic [CHAN_W-1:0]  channels;
    logic [FRAME_W-1:0] frames;
    logic [POINT_W-1:0] points;
  } wpd_cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] peak;
    logic [POINT_W-1:0]  bucket_index;
    logic                run_last;
    logic                final_bucket;
  } wpd_result_t;

endpackage

### rtl/wpd_cfg.sv
module wpd_cfg
  import wpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output wpd_cfg_t              cfg,
  output logic                  restart
);

  logic [CHAN_W-1:0]      channel_count;
  logic [FRAME_W-1:0]     frame_count;
  logic [POINT_W-1:0]     point_count;
  logic [FRAME_W+CAP_SHIFT-1:0] point_cap;
  logic                   wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= RST_CHANNEL_COUNT;
      frame_count   <= RST_FRAME_COUNT;
      point_count   <= RST_POINT_COUNT;
      restart       <= 1'b1;
    end else begin
      restart <= 1'b0;
      if (wr) begin
        case (cfg_index)
          REG_CHANNEL_COUNT: begin
            channel_count <= cfg_data[CHAN_W-1:0];
            restart       <= 1'b1;
          end
          REG_FRAME_COUNT: begin
            frame_count <= cfg_data[FRAME_W-1:0];
            restart     <= 1'b1;
          end
          REG_POINT_COUNT: begin
            point_count <= cfg_data[POINT_W-1:0];
            restart     <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // at most 64 buckets may close on one frame
  assign point_cap = {frame_count, {CAP_SHIFT{1'b0}}};

  always_comb begin
    if (channel_count == '0)
      cfg.channels = CHAN_W'(1);
    else if (channel_count > CHAN_W'(MAX_CH))
      cfg.channels = CHAN_W'(MAX_CH);
    else
      cfg.channels = channel_count;
    cfg.frames = frame_count;
    if ((FRAME_W+CAP_SHIFT)'(point_count) < point_cap)
      cfg.points = point_count;
    else
      cfg.points = point_cap[POINT_W-1:0];
  end

endmodule

### rtl/wpd_engine.sv
module wpd_engine
  import wpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  wpd_cfg_t            cfg,
  input  logic                restart,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                out_free,
  output logic                out_load,
  output wpd_result_t         out_result
);

  logic                hold_valid;
  logic [SAMPLE_W-1:0] hold_sample;
  logic                absorbed;
  logic [CNT_W-1:0]    n_res;
  logic [POS_W-1:0]    chan_pos;
  logic [FRAME_W-1:0]  frames_done;
  logic [POINT_W-1:0]  next_bucket;
  logic [SAMPLE_W-1:0] running_peak;
  logic [PROD_W-1:0]   bep, bep_nx, fp, fp_nx;

  logic                absorbed_next;
  logic [CNT_W-1:0]    n_res_next;
  logic [POS_W-1:0]    chan_pos_next;
  logic [FRAME_W-1:0]  frames_done_next;
  logic [POINT_W-1:0]  next_bucket_next;
  logic [SAMPLE_W-1:0] running_peak_next;
  logic [PROD_W-1:0]   bep_next, bep_nx_next, fp_next, fp_nx_next;

  logic                emit, done, step;
  logic                nonzero, live, wrap, frame_done;
  logic                room_now, room_after, nb_lt, nb1_lt;
  logic                pre_due, pre_more, post_more, post_due;
  logic [SAMPLE_W-1:0] mag, peak_abs;
  logic [PROD_W-1:0]   bep_step, fp_step;

  assign nonzero    = cfg.points != '0;
  assign live       = nonzero && (frames_done < cfg.frames);
  assign wrap       = (CHAN_W'(chan_pos) + CHAN_W'(1)) >= cfg.channels;
  assign frame_done = live && wrap;
  assign room_now   = n_res < CNT_W'(RESULT_LIMIT);
  assign room_after = n_res < CNT_W'(RESULT_LIMIT - 1);
  assign nb_lt      = next_bucket < cfg.points;
  assign nb1_lt     = ((POINT_W+1)'(next_bucket) + (POINT_W+1)'(1)) < (POINT_W+1)'(cfg.points);
  assign mag        = hold_sample[SAMPLE_W-1] ? SAMPLE_W'(-hold_sample) : hold_sample;
  assign bep_step   = bep_nx + PROD_W'(cfg.frames);
  assign fp_step    = fp_nx + PROD_W'(cfg.points);

  assign pre_due  = !absorbed && room_now && nb_lt && (bep < fp);
  assign pre_more = room_after && nb1_lt && (bep_nx < fp);

  always_comb begin
    emit              = 1'b0;
    done              = 1'b0;
    post_more         = 1'b0;
    post_due          = 1'b0;
    peak_abs          = running_peak;
    absorbed_next     = absorbed;
    n_res_next        = n_res;
    chan_pos_next     = chan_pos;
    frames_done_next  = frames_done;
    next_bucket_next  = next_bucket;
    running_peak_next = running_peak;
    bep_next          = bep;
    bep_nx_next       = bep_nx;
    fp_next           = fp;
    fp_nx_next        = fp_nx;
    out_result.peak         = running_peak;
    out_result.bucket_index = next_bucket;
    out_result.final_bucket = next_bucket == (cfg.points - POINT_W'(1));
    out_result.run_last     = 1'b0;

    // absorb the held sample; base peak depends on whether a bucket just left
    if (!absorbed && !(pre_due && pre_more) && live) begin
      if (frame_done) begin
        chan_pos_next    = '0;
        frames_done_next = frames_done + FRAME_W'(1);
        fp_next          = fp_nx;
        fp_nx_next       = fp_step;
      end else begin
        chan_pos_next = chan_pos + POS_W'(1);
      end
    end

    if (pre_due) begin
      emit             = 1'b1;
      next_bucket_next = next_bucket + POINT_W'(1);
      bep_next         = bep_nx;
      bep_nx_next      = bep_step;
      n_res_next       = n_res + CNT_W'(1);
      if (pre_more) begin
        running_peak_next = '0;
      end else begin
        running_peak_next = live ? mag : '0;
        absorbed_next     = 1'b1;
        post_more         = room_after && nb1_lt && frame_done && (bep_nx < fp_nx);
        done              = !post_more;
        out_result.run_last = !post_more;
      end
    end else if (!absorbed) begin
      absorbed_next = 1'b1;
      if (live && (mag > running_peak))
        peak_abs = mag;
      post_due = room_now && nb_lt && frame_done && (bep < fp_nx);
      if (post_due) begin
        emit              = 1'b1;
        out_result.peak   = peak_abs;
        next_bucket_next  = next_bucket + POINT_W'(1);
        bep_next          = bep_nx;
        bep_nx_next       = bep_step;
        running_peak_next = '0;
        n_res_next        = n_res + CNT_W'(1);
        post_more         = room_after && nb1_lt && (bep_nx < fp_nx);
        done              = !post_more;
        out_result.run_last = !post_more;
      end else begin
        running_peak_next = peak_abs;
        done              = 1'b1;
      end
    end else begin
      // drain buckets closed by the absorbed frame
      emit              = 1'b1;
      next_bucket_next  = next_bucket + POINT_W'(1);
      bep_next          = bep_nx;
      bep_nx_next       = bep_step;
      running_peak_next = '0;
      n_res_next        = n_res + CNT_W'(1);
      post_more         = room_after && nb1_lt && (bep_nx < fp);
      done              = !post_more;
      out_result.run_last = !post_more;
    end

    if (done) begin
      absorbed_next = 1'b0;
      n_res_next    = '0;
    end
  end

  assign step     = hold_valid && (!emit || out_free);
  assign out_load = step && emit;
  assign in_ready = !restart && (!hold_valid || (step && done));

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      absorbed   <= 1'b0;
      n_res      <= '0;
    end else if (restart) begin
      hold_valid <= 1'b0;
      absorbed   <= 1'b0;
      n_res      <= '0;
    end else begin
      if (in_valid && in_ready)
        hold_valid <= 1'b1;
      else if (step && done)
        hold_valid <= 1'b0;
      if (step) begin
        absorbed <= absorbed_next;
        n_res    <= n_res_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready)
      hold_sample <= in_sample;
    if (restart) begin
      chan_pos     <= '0;
      frames_done  <= '0;
      next_bucket  <= '0;
      running_peak <= '0;
      bep          <= PROD_W'(cfg.frames);
      bep_nx       <= PROD_W'({cfg.frames, 1'b0});
      fp           <= PROD_W'(cfg.points);
      fp_nx        <= PROD_W'({cfg.points, 1'b0});
    end else if (step) begin
      chan_pos     <= chan_pos_next;
      frames_done  <= frames_done_next;
      next_bucket  <= next_bucket_next;
      running_peak <= running_peak_next;
      bep          <= bep_next;
      bep_nx       <= bep_nx_next;
      fp           <= fp_next;
      fp_nx        <= fp_nx_next;
    end
  end

endmodule

### rtl/wpd_out.sv
module wpd_out
  import wpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  wpd_result_t         result,
  output logic                free,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata,
  output logic                m_tlast,
  output logic                m_tuser
);

  wpd_result_t word;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst)
      m_tvalid <= 1'b0;
    else if (load)
      m_tvalid <= 1'b1;
    else if (m_tready)
      m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load)
      word <= result;
  end

  assign m_tdata = {word.bucket_index, word.peak};
  assign m_tlast = word.run_last;
  assign m_tuser = word.final_bucket;

endmodule

### rtl/waveform_peak_decimator_core.sv
// Peak-decimation waveform overview. Interleaved signed samples of a clip of
// frame_count frames are split into point_count buckets; each bucket reports
// the largest absolute sample over all its channels, in index order, as soon
// as its last frame is complete (empty buckets report zero). The block takes
// one sample per cycle while a sample releases at most one bucket and the
// output is free; a sample that releases more buckets keeps the engine and
// stalls the input while they drain, since the bucket drain hands one word
// per cycle to the output register, and a stalled output stalls the drain.
// At most 64 words follow one sample; held-over empty buckets go out ahead
// of the next sample. Any write to a listed register restarts the run and
// holds the input while its restart strobe is high.
module waveform_peak_decimator_core
  import wpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [15:0] sample
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // [15:0] peak, [31:16] bucket_index
  output logic                  m_tlast,   // run_last
  output logic                  m_tuser,   // [0] final_bucket
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  wpd_cfg_t    cfg;
  wpd_result_t result;
  logic        restart;
  logic        out_free;
  logic        out_load;

  wpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .restart   (restart)
  );

  wpd_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .restart    (restart),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_sample  (s_tdata),
    .out_free   (out_free),
    .out_load   (out_load),
    .out_result (result)
  );

  wpd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .result   (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

### test/bucket_peak_checker.sv
`timescale 1ns / 100ps

module bucket_peak_checker
  import wpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [15:0] sample
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [31:0]           m_tdata,   // [15:0] peak, [31:16] bucket_index
  input  logic                  m_tlast,   // run_last
  input  logic                  m_tuser,   // [0] final_bucket
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    failures,
  output int                    pending
);

  logic [CHAN_W-1:0]   cur_channels;
  logic [FRAME_W-1:0]  cur_frames;
  logic [POINT_W-1:0]  cur_points;

  logic [CHAN_W-1:0]   chan_pos;
  logic [FRAME_W-1:0]  frames_seen;
  logic [POINT_W-1:0]  bucket_next;
  logic [SAMPLE_W-1:0] peak_so_far;
  logic [PROD_W-1:0]   bucket_end;   // (bucket_next + 1) * frames
  logic [PROD_W-1:0]   frame_mark;   // (frames_seen + 1) * points
  logic                presented_done;
  int                  fail_total;

  wpd_result_t expected_buckets[$];

  // bucket count after the 64-per-frame cap
  function automatic logic [POINT_W-1:0] active_points();
    logic [FRAME_W+CAP_SHIFT-1:0] cap;
    cap = {cur_frames, {CAP_SHIFT{1'b0}}};
    if (cap < cur_points) return cap[POINT_W-1:0];
    return cur_points;
  endfunction

  function automatic logic [CHAN_W-1:0] active_channels();
    if (cur_channels == '0) return CHAN_W'(1);
    if (cur_channels > CHAN_W'(MAX_CH)) return CHAN_W'(MAX_CH);
    return cur_channels;
  endfunction

  task automatic restart_clip();
    chan_pos       = '0;
    frames_seen    = '0;
    bucket_next    = '0;
    peak_so_far    = '0;
    bucket_end     = PROD_W'(cur_frames);
    frame_mark     = PROD_W'(active_points());
    presented_done = 1'b0;
  endtask

  task automatic release_due(input logic [POINT_W-1:0] np, inout int n);
    wpd_result_t item;
    while (n < RESULT_LIMIT && bucket_next < np && bucket_end < frame_mark) begin
      item.peak         = peak_so_far;
      item.bucket_index = bucket_next;
      item.run_last     = 1'b0;
      item.final_bucket = (bucket_next == np - POINT_W'(1));
      expected_buckets.push_back(item);
      bucket_next = bucket_next + POINT_W'(1);
      bucket_end  = bucket_end + PROD_W'(cur_frames);
      peak_so_far = '0;
      n++;
    end
  endtask

  task automatic absorb_sample(input logic [SAMPLE_W-1:0] smp);
    logic [POINT_W-1:0]  np;
    logic [SAMPLE_W:0]   mag;
    wpd_result_t         tail;
    int                  n;
    np = active_points();
    n  = 0;
    if (np == '0) return;
    release_due(np, n);
    if (frames_seen < cur_frames) begin
      mag = smp[SAMPLE_W-1] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
      if (mag > {1'b0, peak_so_far}) peak_so_far = mag[SAMPLE_W-1:0];
      chan_pos = chan_pos + CHAN_W'(1);
      if (chan_pos >= active_channels()) begin
        chan_pos    = '0;
        frames_seen = frames_seen + FRAME_W'(1);
        frame_mark  = frame_mark + PROD_W'(np);
        release_due(np, n);
      end
    end
    if (n > 0) begin
      tail = expected_buckets.pop_back();
      tail.run_last = 1'b1;
      expected_buckets.push_back(tail);
    end
  endtask

  task automatic flag_mismatch(input string what, input wpd_result_t want,
                               input wpd_result_t got);
    fail_total++;
    if (fail_total <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected peak %0d bucket %0d last %0b final %0b",
               want.peak, want.bucket_index, want.run_last, want.final_bucket);
      $display("  actual   peak %0d bucket %0d last %0b final %0b",
               got.peak, got.bucket_index, got.run_last, got.final_bucket);
    end
  endtask

  always @(posedge clk) begin
    wpd_result_t got;
    wpd_result_t want;
    logic        took;
    if (rst) begin
      cur_channels = RST_CHANNEL_COUNT;
      cur_frames   = RST_FRAME_COUNT;
      cur_points   = RST_POINT_COUNT;
      fail_total   = 0;
      restart_clip();
      expected_buckets.delete();
    end else begin
      took = 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CHANNEL_COUNT: begin
            cur_channels = cfg_data[CHAN_W-1:0];
            restart_clip();
          end
          REG_FRAME_COUNT: begin
            cur_frames = cfg_data[FRAME_W-1:0];
            restart_clip();
          end
          REG_POINT_COUNT: begin
            cur_points = cfg_data[POINT_W-1:0];
            restart_clip();
          end
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (!presented_done) absorb_sample(s_tdata);
        presented_done = 1'b0;
        took = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        // held buckets may leave while their sample is still waiting at the input
        if (expected_buckets.size() == 0 && s_tvalid && !took && !presented_done) begin
          absorb_sample(s_tdata);
          presented_done = 1'b1;
        end
        got.peak         = m_tdata[15:0];
        got.bucket_index = m_tdata[31:16];
        got.run_last     = m_tlast;
        got.final_bucket = m_tuser;
        if (expected_buckets.size() == 0) begin
          flag_mismatch("word with no bucket expected", '0, got);
        end else begin
          want = expected_buckets.pop_front();
          if (got.peak !== want.peak || got.bucket_index !== want.bucket_index ||
              got.run_last !== want.run_last || got.final_bucket !== want.final_bucket)
            flag_mismatch("bucket word mismatch", want, got);
        end
      end
    end
    failures <= fail_total;
    pending  <= expected_buckets.size();
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import wpd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNLISTED = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata   = '0;   // [15:0] sample
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [31:0]           m_tdata;          // [15:0] peak, [31:16] bucket_index
  logic                  m_tlast;          // run_last
  logic                  m_tuser;          // [0] final_bucket
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int failures;
  int pending;
  int src_idle   = 35;
  int dst_idle   = 77;
  int rand_items = 0;

  waveform_peak_decimator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bucket_peak_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= dst_idle);

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [15:0] pick_sample();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(7))
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = {12'h000, v[3:0]};
      3: v = {12'hFFF, v[3:0]};
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_sample(input logic [15:0] smp);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic end_burst();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // wait for every expected bucket, then let the block go quiet
  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic send_clip(input int n, input bit counted);
    for (int i = 0; i < n; i++) begin
      if (counted) begin
        if (rand_items < 90) begin
          src_idle = 35;
          dst_idle = 77;
        end else if (rand_items < 180) begin
          src_idle = 77;
          dst_idle = 35;
        end else begin
          src_idle = 0;
          dst_idle = 0;
        end
        rand_items++;
      end
      send_sample(pick_sample());
    end
    end_burst();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // unused upper data bits carry noise
  task automatic configure(input int channels, input int frames, input int points);
    logic [CFG_DATA_W-1:0] junk;
    settle();
    junk = 24'($urandom);
    write_reg(REG_CHANNEL_COUNT, {junk[23:4], 4'(channels)});
    write_reg(REG_FRAME_COUNT, 24'(frames));
    junk = 24'($urandom);
    write_reg(REG_POINT_COUNT, {junk[23:16], 16'(points)});
  endtask

  initial begin
    int ch;
    int eff_ch;
    int frames;
    int points;
    int full;
    int n;
    int first;
    int sel;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // reset settings: one stereo frame, 64 buckets, all but the last empty
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h1234);
    end_burst();

    // one bucket per frame, trailing sample dropped
    configure(1, 4, 4);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    end_burst();

    // channel count above the maximum, leading empty buckets
    configure(15, 1, 3);
    send_clip(8, 1'b0);

    // zero channels, zero buckets
    configure(0, 2, 0);
    send_clip(2, 1'b0);

    // zero frames
    configure(3, 0, 500);
    send_clip(1, 1'b0);

    // more than 64 due at once: hold over, release ahead of the following samples
    configure(1, 3, 150);
    send_clip(5, 1'b0);

    while (rand_items < 270) begin
      sel = $urandom_range(19);
      if (sel < 14) ch = $urandom_range(1, 3);
      else if (sel < 17) ch = $urandom_range(4, 8);
      else ch = $urandom_range(0, 15);
      eff_ch = (ch == 0) ? 1 : (ch > 8) ? 8 : ch;

      sel = $urandom_range(9);
      if (sel < 8) frames = $urandom_range(1, 10);
      else if (sel == 8) frames = $urandom_range(11, 40);
      else if ($urandom_range(1) == 0) frames = 24'hFFFFFF;
      else frames = $urandom_range(24'h800000, 24'hFFFFFF);

      case ($urandom_range(9))
        0: points = 0;
        1: points = 1;
        2: points = 16'hFFFF;
        3: points = (frames <= 1023) ? frames * 64 : $urandom_range(0, 65535);
        4: points = (frames <= 65535) ? frames : 65535;
        default: points = $urandom_range(2, (frames <= 1023) ? frames * 12 : 65535);
      endcase

      full = eff_ch * frames;
      if (frames > 40) n = $urandom_range(8, 30);
      else if ($urandom_range(5) == 0) n = $urandom_range(1, full);
      else n = full + $urandom_range(0, 2);
      // keep the total near the item budget
      if (n > 270 - rand_items) n = 270 - rand_items;

      configure(ch, frames, points);
      first = $urandom_range(0, n);
      send_clip(first, 1'b1);
      sel = $urandom_range(7);
      if (sel < 2) begin
        // a write to no register leaves the clip running
        settle();
        write_reg(REG_UNLISTED, 24'($urandom));
      end else if (sel == 2) begin
        // rewrite mid clip: the run starts over
        settle();
        write_reg(REG_CHANNEL_COUNT, 24'(ch));
      end
      send_clip(n - first, 1'b1);
    end

    settle();
    if (failures == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
